// File: sv/binary32_float_multiplier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the multiplier RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY32_FLOAT_MULTIPLIER_MACROS_SVH
`define BINARY32_FLOAT_MULTIPLIER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define B32M_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define B32M_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/b32m_pkg.sv
// ----------------------------------------------------------------------------
// b32m_pkg
// Constants and types shared by the binary32 multiplier modules.
// ----------------------------------------------------------------------------
package b32m_pkg;
    localparam int unsigned FracBits = 23;
    localparam int unsigned ExpBits  = 8;
    localparam logic [9:0]  ExpBias  = 10'd127;
    localparam logic [9:0]  ExpMax   = 10'd255;

    typedef logic [31:0] word_t;
endpackage

// File: sv/b32m_core.sv
// ----------------------------------------------------------------------------
// b32m_core
// Combinational truncating multiply of two binary32 patterns.
// ----------------------------------------------------------------------------
module b32m_core (
    input  b32m_pkg::word_t a,
    input  b32m_pkg::word_t b,
    output b32m_pkg::word_t p
);
    import b32m_pkg::*;

    logic        zero_in;
    logic        sign;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] prod;
    logic [9:0]  exp_sum;
    logic [9:0]  exp_norm;
    logic [22:0] frac;

    assign zero_in  = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
    assign sign     = a[31] ^ b[31];
    assign ma       = {1'b1, a[22:0]};
    assign mb       = {1'b1, b[22:0]};
    assign prod     = ma * mb;
    assign exp_sum  = {2'b00, a[30:23]} + {2'b00, b[30:23]} - ExpBias;
    assign exp_norm = exp_sum + {9'd0, prod[47]};
    assign frac     = prod[47] ? prod[46:24] : prod[45:23];

    always_comb begin
        if (zero_in) begin
            p = '0;
        end else if (!exp_norm[9] && (exp_norm >= ExpMax)) begin
            p = {sign, 8'hFF, 23'd0};
        end else if (exp_norm[9] || (exp_norm == 10'd0)) begin
            p = '0;
        end else begin
            p = {sign, exp_norm[7:0], frac};
        end
    end
endmodule

// File: sv/binary32_float_multiplier.sv
// Path: an input beat passes the input register, then the result register, to become a result beat.
// Throughput: one beat per cycle while the output is not stalled; one 24x24 multiplier between the two registers.
// Input stays ready while the result register is empty or being drained.
// Reset: aresetn synchronous active low clears both valid flags.
// ----------------------------------------------------------------------------
// binary32_float_multiplier
// Streaming truncating binary32 multiplier.
// ----------------------------------------------------------------------------
`include "binary32_float_multiplier_macros.svh"
module binary32_float_multiplier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // product [31:0]
);
    import b32m_pkg::*;

    logic  in_valid_reg;
    word_t a_reg;
    word_t b_reg;
    logic  out_valid_reg;
    word_t out_reg;
    word_t prod;
    logic  adv;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;

    b32m_core u_core (.a(a_reg), .b(b_reg), .p(prod));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
        end
        if (adv && in_valid_reg) begin
            out_reg <= prod;
        end
        if (s_tready && s_tvalid) begin
            a_reg <= s_tdata[31:0];
            b_reg <= s_tdata[63:32];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `B32M_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `B32M_ASSERT_IMPL(a_ready, aclk, aresetn, !in_valid_reg, s_tready)
    `B32M_ASSERT_NEXT(a_fill, aclk, aresetn, in_valid_reg && adv, out_valid_reg)
endmodule
